// ===== sv/rps_pkg.sv =====
// Shared types, constants and command codes for the repeat playlist sequencer.
package rps_pkg;

    localparam int DEPTH      = 64;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int PAT_W      = 8;
    localparam int REP_W      = 7;
    localparam int MAX_REPEAT = 99;
    localparam int IN_W       = 32;
    localparam int OUT_W      = 40;

    typedef enum logic [3:0] {
        CMD_ADVANCE  = 4'd0,
        CMD_PEEK     = 4'd1,
        CMD_APPEND   = 4'd2,
        CMD_WRITE    = 4'd3,
        CMD_REMOVE   = 4'd4,
        CMD_SET_REP  = 4'd5,
        CMD_SET_SKIP = 4'd6,
        CMD_READ     = 4'd7,
        CMD_CLEAR    = 4'd8,
        CMD_REWIND   = 4'd9,
        CMD_SEEK     = 4'd10
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef struct packed {
        logic             skip;
        logic [REP_W-1:0] rep;
        logic [PAT_W-1:0] pat;
    } entry_t;

    typedef struct packed {
        logic [IDX_W-1:0] rd_addr;
        logic [IDX_W-1:0] wr_addr;
        logic             we_pat;
        logic             we_rep;
        logic             we_skip;
        entry_t           wr_data;
    } mem_req_t;

    typedef struct packed {
        logic [PAT_W-1:0] pattern;
        logic             found;
        logic [REP_W-1:0] rep;
        logic             skip;
        status_t          status;
    } result_t;

endpackage

// ===== sv/rps_mem.sv =====
// Entry store: per-field write enables, one read port with registered data.
module rps_mem (
    input  logic              clk,
    input  rps_pkg::mem_req_t req,
    output rps_pkg::entry_t   rd_data
);
    import rps_pkg::*;

    logic [PAT_W-1:0] pat_mem  [DEPTH];
    logic [REP_W-1:0] rep_mem  [DEPTH];
    logic             skip_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we_pat)
        begin
            pat_mem[req.wr_addr] <= req.wr_data.pat;
        end
        if (req.we_rep)
        begin
            rep_mem[req.wr_addr] <= req.wr_data.rep;
        end
        if (req.we_skip)
        begin
            skip_mem[req.wr_addr] <= req.wr_data.skip;
        end
        rd_data.pat  <= pat_mem[req.rd_addr];
        rd_data.rep  <= rep_mem[req.rd_addr];
        rd_data.skip <= skip_mem[req.rd_addr];
    end

endmodule

// ===== sv/rps_ctrl.sv =====
// Command sequencer: play state registers and read-modify-write of the entry store.
module rps_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      chain_enabled,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [3:0]                in_cmd,
    input  logic [rps_pkg::IDX_W-1:0] in_idx,
    input  logic [rps_pkg::PAT_W-1:0] in_pat,
    input  logic [7:0]                in_rep,
    input  logic                      in_skip,
    output rps_pkg::mem_req_t         mem_req,
    input  rps_pkg::entry_t           mem_rd,
    output logic                      res_valid,
    input  logic                      res_ready,
    output rps_pkg::result_t          res,
    output logic [rps_pkg::IDX_W-1:0] pos,
    output logic [rps_pkg::REP_W-1:0] prog,
    output logic [rps_pkg::CNT_W-1:0] count
);
    import rps_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_ADV_RD, S_ADV_CHK, S_WALK_RD, S_WALK_CHK, S_FILL,
        S_RM_RD, S_RM_WR, S_READ_RD, S_READ_CHK, S_DONE
    } state_t;

    state_t           state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [PAT_W-1:0] pat_reg, pat_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic [REP_W-1:0] rtmp_reg, rtmp_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [REP_W-1:0] prog_reg, prog_next;
    logic [CNT_W-1:0] count_reg, count_next;
    result_t          res_reg, res_next;

    logic             idx_valid;
    logic [REP_W-1:0] rep_clamped;
    logic [REP_W-1:0] rep_cur;
    logic [REP_W:0]   r_inc;
    logic [IDX_W-1:0] ptr_wrap;
    logic [CNT_W-1:0] ptr_inc;
    logic [CNT_W-1:0] new_count;
    logic [CNT_W-1:0] fix_pos;
    logic             playable;

    assign idx_valid   = {1'b0, in_idx} < count_reg;
    assign rep_clamped = (in_rep == 8'd0) ? REP_W'(1) :
                         (in_rep > 8'(MAX_REPEAT)) ? REP_W'(MAX_REPEAT) : in_rep[REP_W-1:0];
    assign rep_cur     = ({1'b0, pos_reg} < count_reg) ? mem_rd.rep : REP_W'(1);
    assign r_inc       = {1'b0, prog_reg} + (REP_W + 1)'(1);
    assign ptr_inc     = {1'b0, ptr_reg} + CNT_W'(1);
    assign ptr_wrap    = (ptr_inc == count_reg) ? '0 : ptr_inc[IDX_W-1:0];
    assign new_count   = count_reg - CNT_W'(1);
    assign playable    = !mem_rd.skip && (mem_rd.pat != '0);

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;
    assign pos       = pos_reg;
    assign prog      = prog_reg;
    assign count     = count_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        idx_next   = idx_reg;
        pat_next   = pat_reg;
        ptr_next   = ptr_reg;
        rtmp_next  = rtmp_reg;
        pos_next   = pos_reg;
        prog_next  = prog_reg;
        count_next = count_reg;
        res_next   = res_reg;
        fix_pos    = '0;
        mem_req    = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = cmd_t'(in_cmd);
                    idx_next   = in_idx;
                    pat_next   = in_pat;
                    res_next   = '{pattern: '0, found: 1'b0, rep: REP_W'(1),
                                   skip: 1'b0, status: ST_OK};
                    state_next = S_DONE;
                    case (in_cmd)
                        CMD_ADVANCE, CMD_PEEK:
                        begin
                            if (chain_enabled && count_reg != '0)
                            begin
                                state_next = S_ADV_RD;
                            end
                        end
                        CMD_APPEND:
                        begin
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                mem_req.wr_addr = count_reg[IDX_W-1:0];
                                mem_req.wr_data = '{skip: 1'b0, rep: REP_W'(1), pat: in_pat};
                                mem_req.we_pat  = 1'b1;
                                mem_req.we_rep  = 1'b1;
                                mem_req.we_skip = 1'b1;
                                count_next      = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_WRITE:
                        begin
                            ptr_next   = idx_valid ? in_idx : count_reg[IDX_W-1:0];
                            state_next = S_FILL;
                        end
                        CMD_REMOVE:
                        begin
                            if (idx_valid)
                            begin
                                ptr_next   = in_idx;
                                state_next = S_RM_RD;
                            end
                            else
                            begin
                                res_next.status = ST_INVALID;
                            end
                        end
                        CMD_SET_REP:
                        begin
                            if (idx_valid)
                            begin
                                mem_req.wr_addr     = in_idx;
                                mem_req.wr_data.rep = rep_clamped;
                                mem_req.we_rep      = 1'b1;
                            end
                            else
                            begin
                                res_next.status = ST_INVALID;
                            end
                        end
                        CMD_SET_SKIP:
                        begin
                            if (idx_valid)
                            begin
                                mem_req.wr_addr      = in_idx;
                                mem_req.wr_data.skip = in_skip;
                                mem_req.we_skip      = 1'b1;
                            end
                            else
                            begin
                                res_next.status = ST_INVALID;
                            end
                        end
                        CMD_READ:
                        begin
                            if (idx_valid)
                            begin
                                state_next = S_READ_RD;
                            end
                            else
                            begin
                                res_next.status = ST_INVALID;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                            pos_next   = '0;
                            prog_next  = '0;
                        end
                        CMD_REWIND:
                        begin
                            pos_next  = '0;
                            prog_next = '0;
                        end
                        CMD_SEEK:
                        begin
                            if (idx_valid)
                            begin
                                pos_next  = in_idx;
                                prog_next = '0;
                            end
                            else
                            begin
                                res_next.status = ST_INVALID;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_ADV_RD:
            begin
                mem_req.rd_addr = pos_reg;
                state_next      = S_ADV_CHK;
            end
            S_ADV_CHK:
            begin
                if (r_inc >= {1'b0, rep_cur})
                begin
                    ptr_next   = pos_reg;
                    rtmp_next  = '0;
                    state_next = S_WALK_RD;
                end
                else
                begin
                    res_next.found   = playable && ({1'b0, pos_reg} < count_reg);
                    res_next.pattern = res_next.found ? mem_rd.pat : '0;
                    if (cmd_reg == CMD_ADVANCE)
                    begin
                        prog_next = r_inc[REP_W-1:0];
                    end
                    state_next = S_DONE;
                end
            end
            S_WALK_RD:
            begin
                mem_req.rd_addr = ptr_wrap;
                ptr_next        = ptr_wrap;
                state_next      = S_WALK_CHK;
            end
            S_WALK_CHK:
            begin
                // stop on an enabled entry, or when the walk is back at its start
                if (ptr_reg == pos_reg || !mem_rd.skip)
                begin
                    res_next.found   = playable;
                    res_next.pattern = playable ? mem_rd.pat : '0;
                    if (cmd_reg == CMD_ADVANCE)
                    begin
                        pos_next  = ptr_reg;
                        prog_next = rtmp_reg;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_WALK_RD;
                end
            end
            S_FILL:
            begin
                mem_req.wr_addr = ptr_reg;
                mem_req.we_pat  = 1'b1;
                if (ptr_reg == idx_reg)
                begin
                    mem_req.wr_data = '{skip: 1'b0, rep: REP_W'(1), pat: pat_reg};
                    if ({1'b0, idx_reg} >= count_reg)
                    begin
                        mem_req.we_rep  = 1'b1;
                        mem_req.we_skip = 1'b1;
                        count_next      = {1'b0, idx_reg} + CNT_W'(1);
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    // empty slot between the old end and the written index
                    mem_req.wr_data = '{skip: 1'b0, rep: REP_W'(1), pat: '0};
                    mem_req.we_rep  = 1'b1;
                    mem_req.we_skip = 1'b1;
                    ptr_next        = ptr_inc[IDX_W-1:0];
                end
            end
            S_RM_RD:
            begin
                if (ptr_inc < count_reg)
                begin
                    mem_req.rd_addr = ptr_inc[IDX_W-1:0];
                    state_next      = S_RM_WR;
                end
                else
                begin
                    fix_pos = {1'b0, pos_reg};
                    if (pos_reg > idx_reg)
                    begin
                        fix_pos = fix_pos - CNT_W'(1);
                    end
                    if (fix_pos >= new_count)
                    begin
                        fix_pos = (new_count != '0) ? new_count - CNT_W'(1) : '0;
                    end
                    pos_next   = fix_pos[IDX_W-1:0];
                    count_next = new_count;
                    if (pos_reg == idx_reg)
                    begin
                        prog_next = '0;
                    end
                    state_next = S_DONE;
                end
            end
            S_RM_WR:
            begin
                mem_req.wr_addr = ptr_reg;
                mem_req.wr_data = mem_rd;
                mem_req.we_pat  = 1'b1;
                mem_req.we_rep  = 1'b1;
                mem_req.we_skip = 1'b1;
                ptr_next        = ptr_inc[IDX_W-1:0];
                state_next      = S_RM_RD;
            end
            S_READ_RD:
            begin
                mem_req.rd_addr = idx_reg;
                state_next      = S_READ_CHK;
            end
            S_READ_CHK:
            begin
                res_next.pattern = mem_rd.pat;
                res_next.rep     = mem_rd.rep;
                res_next.skip    = mem_rd.skip;
                state_next       = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pos_reg   <= '0;
            prog_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            prog_reg  <= prog_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        idx_reg  <= idx_next;
        pat_reg  <= pat_next;
        ptr_reg  <= ptr_next;
        rtmp_reg <= rtmp_next;
        res_reg  <= res_next;
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");
    a_pos_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 && pos_reg == '0) || ({1'b0, pos_reg} < count_reg))
        else $error("play position outside list");
    a_prog_range: assert property (@(posedge clk) disable iff (!rst_n)
        prog_reg < REP_W'(MAX_REPEAT))
        else $error("repeat progress out of range");
    a_idle_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && res_ready) |=> (state_reg == S_IDLE))
        else $error("result taken but sequencer not idle");
`endif

endmodule

// ===== sv/repeat_playlist_sequencer_top.sv =====
// Top level of the repeat playlist sequencer: ports, config register, output register.
//
//  channel   dir  handshake          payload
//  s_axis    in   s_tvalid/s_tready  s_tdata[31:0]  command item
//  m_axis    out  m_tvalid/m_tready  m_tdata[39:0]  result item
//  cfg       in   cfg_we             cfg_data       chain_enabled
//
// An accepted item holds the sequencer until its result is passed on: register-only
// commands and one-slot edits go straight to the result, read and advance/peek read
// the entry store first, a wrap walks entries and a remove shifts them one by one, and
// a write that grows the list fills each new slot; the single read port sets this.
// Reset clears entry count, position, progress and sets chain_enabled.
// A result waits in the output register while m_tready is low; the next item
// is accepted meanwhile and its result holds the sequencer until the register frees.
module repeat_playlist_sequencer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cmd[3:0], entry_index[9:4], pattern_in[17:10], repeat_value[25:18],
    // skip_value[26], zero pad [31:27]
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // pattern_out[7:0], pattern_found[8], position_out[14:9],
    // progress_out[21:15], repeat_out[28:22], skip_out[29],
    // length_out[36:30], status[38:37], zero pad [39]
    output logic [39:0] m_tdata,
    input  logic        cfg_we,
    input  logic        cfg_data
);
    import rps_pkg::*;

    logic             chain_en_reg;
    logic             m_valid_reg;
    logic [OUT_W-1:0] m_data_reg;

    mem_req_t         mem_req;
    entry_t           mem_rd;
    result_t          res;
    logic             res_valid;
    logic             res_ready;
    logic [IDX_W-1:0] pos;
    logic [REP_W-1:0] prog;
    logic [CNT_W-1:0] count;

    rps_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (mem_rd)
    );

    rps_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .chain_enabled (chain_en_reg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_cmd        (s_tdata[3:0]),
        .in_idx        (s_tdata[9:4]),
        .in_pat        (s_tdata[17:10]),
        .in_rep        (s_tdata[25:18]),
        .in_skip       (s_tdata[26]),
        .mem_req       (mem_req),
        .mem_rd        (mem_rd),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .pos           (pos),
        .prog          (prog),
        .count         (count)
    );

    // output register frees when empty or being taken
    assign res_ready = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_en_reg <= 1'b1;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                chain_en_reg <= cfg_data;
            end
            if (res_ready)
            begin
                m_valid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            m_data_reg <= {1'b0, res.status, count, res.skip, res.rep, prog, pos,
                           res.found, res.pattern};
        end
    end

endmodule

// ===== verif/repeat_playlist_sequencer_top_tb.sv =====
// Self-checking testbench for the repeat playlist sequencer: directed and random commands.
module repeat_playlist_sequencer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rps_pkg::*;

    // Codes 11..15 are not commands; the block must ignore them with status ok.
    localparam logic [3:0] CMD_UNKNOWN_LO = 4'd11;
    localparam logic [3:0] CMD_UNKNOWN_HI = 4'd15;
    localparam int DRAIN_CYCLES = 300;      // enough for the longest walk or shift
    localparam int CYCLE_LIMIT  = 2000000;

    typedef struct packed {
        logic       skip;
        logic [7:0] rep;
        logic [7:0] pat;
        logic [5:0] idx;
        logic [3:0] cmd;
    } cmd_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] length;
        logic       skip;
        logic [6:0] rep;
        logic [6:0] progress;
        logic [5:0] position;
        logic       found;
        logic [7:0] pattern;
    } play_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        cfg_we;
    logic        cfg_data;

    repeat_playlist_sequencer_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always #10 clk = ~clk;

    cmd_item_t    cmd_queue[$];      // commands waiting to be offered
    play_result_t answer_queue[$];   // predicted results, oldest first
    int           cycle_count;
    int           fail_count;
    bit           item_taken;

    // Shadow copy of the playlist
    logic [7:0] list_pat [DEPTH];
    logic [6:0] list_rep [DEPTH];
    logic       list_skip[DEPTH];
    int         list_len;
    int         play_pos;
    int         play_prog;
    bit         chain_on;

    function automatic bit entry_skipped(int i);
        return i < list_len && list_skip[i];
    endfunction

    function automatic int entry_repeat(int i);
        return i < list_len ? int'(list_rep[i]) : 1;
    endfunction

    // Applies one command to the shadow list and returns the result it should produce.
    function automatic play_result_t sequence_command(cmd_item_t c);
        play_result_t res;
        int p;
        int r;
        int start;
        bit ok;
        bit was_cur;
        ok = c.idx < list_len;
        res = '0;
        res.rep = 7'd1;
        res.status = ST_OK;
        case (c.cmd)
            CMD_ADVANCE, CMD_PEEK:
                if (chain_on && list_len != 0)
                begin
                    p = play_pos;
                    r = play_prog + 1;
                    if (r >= entry_repeat(p))
                    begin
                        start = p;
                        r = 0;
                        for (int n = 0; n < list_len; n++)
                        begin
                            p = (p + 1) % list_len;
                            if (p == start || !entry_skipped(p))
                                break;
                        end
                    end
                    if (p < list_len && !entry_skipped(p) && list_pat[p] != 0)
                    begin
                        res.found = 1'b1;
                        res.pattern = list_pat[p];
                    end
                    if (c.cmd == CMD_ADVANCE)
                    begin
                        play_pos = p;
                        play_prog = r;
                    end
                end
            CMD_APPEND:
                if (list_len >= DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    list_pat[list_len] = c.pat;
                    list_rep[list_len] = 7'd1;
                    list_skip[list_len] = 1'b0;
                    list_len++;
                end
            CMD_WRITE:
            begin
                // every 6-bit index is inside DEPTH, so a write always lands
                for (int i = list_len; i <= c.idx; i++)
                begin
                    list_pat[i] = '0;
                    list_rep[i] = 7'd1;
                    list_skip[i] = 1'b0;
                end
                if (c.idx >= list_len)
                    list_len = c.idx + 1;
                list_pat[c.idx] = c.pat;
            end
            CMD_REMOVE:
                if (!ok)
                    res.status = ST_INVALID;
                else
                begin
                    was_cur = play_pos == c.idx;
                    for (int i = c.idx; i + 1 < list_len; i++)
                    begin
                        list_pat[i] = list_pat[i+1];
                        list_rep[i] = list_rep[i+1];
                        list_skip[i] = list_skip[i+1];
                    end
                    list_len--;
                    if (play_pos > c.idx)
                        play_pos--;
                    if (play_pos >= list_len)
                        play_pos = list_len != 0 ? list_len - 1 : 0;
                    if (was_cur)
                        play_prog = 0;
                end
            CMD_SET_REP:
                if (!ok)
                    res.status = ST_INVALID;
                else
                    list_rep[c.idx] = c.rep < 1 ? 7'd1 :
                                      c.rep > MAX_REPEAT ? 7'(MAX_REPEAT) : c.rep[6:0];
            CMD_SET_SKIP:
                if (!ok)
                    res.status = ST_INVALID;
                else
                    list_skip[c.idx] = c.skip;
            CMD_READ:
                if (!ok)
                    res.status = ST_INVALID;
                else
                begin
                    res.pattern = list_pat[c.idx];
                    res.rep = list_rep[c.idx];
                    res.skip = list_skip[c.idx];
                end
            CMD_CLEAR:
            begin
                list_len = 0;
                play_pos = 0;
                play_prog = 0;
            end
            CMD_REWIND:
            begin
                play_pos = 0;
                play_prog = 0;
            end
            CMD_SEEK:
                if (!ok)
                    res.status = ST_INVALID;
                else
                begin
                    play_pos = c.idx;
                    play_prog = 0;
                end
            default: ;
        endcase
        res.position = play_pos[5:0];
        res.progress = play_prog[6:0];
        res.length = list_len[6:0];
        return res;
    endfunction

    function automatic cmd_item_t make_cmd(logic [3:0] op, int idx, int pat, int rep, bit skip);
        cmd_item_t c;
        c.cmd = op;
        c.idx = idx[5:0];
        c.pat = pat[7:0];
        c.rep = rep[7:0];
        c.skip = skip;
        return c;
    endfunction

    // Appends one command to the tail of the pending list
    function automatic void add_cmd(cmd_item_t c);
        cmd_queue.insert(cmd_queue.size(), c);
    endfunction

    // Random command, weighted toward playback so that walks and wraps get exercised.
    function automatic cmd_item_t random_cmd();
        int w;
        logic [3:0] op;
        int idx;
        int rep;
        w = $urandom_range(0, 99);
        if (w < 34)      op = CMD_ADVANCE;
        else if (w < 42) op = CMD_PEEK;
        else if (w < 54) op = CMD_APPEND;
        else if (w < 61) op = CMD_WRITE;
        else if (w < 67) op = CMD_REMOVE;
        else if (w < 75) op = CMD_SET_REP;
        else if (w < 84) op = CMD_SET_SKIP;
        else if (w < 91) op = CMD_READ;
        else if (w < 92) op = CMD_CLEAR;
        else if (w < 94) op = CMD_REWIND;
        else if (w < 98) op = CMD_SEEK;
        else             op = 4'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
        // mostly small indexes so they hit the list; now and then any index
        idx = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 15) : $urandom_range(0, 63);
        // short repeats keep the play position moving; sometimes the clamp edges
        case ($urandom_range(0, 9))
            0:       rep = $urandom_range(0, 255);
            1:       rep = $urandom_range(0, 1) ? 0 : 255;
            2:       rep = $urandom_range(98, 100);
            default: rep = $urandom_range(1, 4);
        endcase
        return make_cmd(op, idx, $urandom_range(0, 255), rep, $urandom_range(0, 1));
    endfunction

    // Idle at random with a chance of 19 in 100, except in one quiet stretch where it never idles
    function automatic bit idle_now();
        if (cycle_count >= 1500 && cycle_count < 3000)
            return 1'b0;
        return $urandom_range(0, 99) < 19;
    endfunction

    // Input side: accept at the rising edge, predict right away.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        item_taken = 1'b0;
        if (rst_n && s_tvalid && s_tready)
        begin
            answer_queue.insert(answer_queue.size(), sequence_command(cmd_queue.pop_front()));
            item_taken = 1'b1;
        end
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Driver: new values at the falling edge; a pending item holds until taken.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!(s_tvalid && !item_taken))
            begin
                if (cmd_queue.size() > 0 && !idle_now())
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {5'b0, cmd_queue[0]};
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= !idle_now();
        end
    end

    // Monitor: compare each result with the oldest prediction.
    always @(posedge clk)
    begin
        play_result_t got;
        play_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[38:0];
            if (answer_queue.size() == 0)
            begin
                $error("unexpected result item %h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = answer_queue.pop_front();
                if (got.pattern !== want.pattern)
                begin
                    $error("pattern_out exp %0d got %0d", want.pattern, got.pattern);
                    fail_count++;
                end
                if (got.found !== want.found)
                begin
                    $error("pattern_found exp %0d got %0d", want.found, got.found);
                    fail_count++;
                end
                if (got.position !== want.position)
                begin
                    $error("position_out exp %0d got %0d", want.position, got.position);
                    fail_count++;
                end
                if (got.progress !== want.progress)
                begin
                    $error("progress_out exp %0d got %0d", want.progress, got.progress);
                    fail_count++;
                end
                if (got.rep !== want.rep)
                begin
                    $error("repeat_out exp %0d got %0d", want.rep, got.rep);
                    fail_count++;
                end
                if (got.skip !== want.skip)
                begin
                    $error("skip_out exp %0d got %0d", want.skip, got.skip);
                    fail_count++;
                end
                if (got.length !== want.length)
                begin
                    $error("length_out exp %0d got %0d", want.length, got.length);
                    fail_count++;
                end
                if (got.status !== want.status)
                begin
                    $error("status exp %0d got %0d", want.status, got.status);
                    fail_count++;
                end
                if (m_tdata[39] !== 1'b0)
                begin
                    $error("pad bit exp 0 got %b", m_tdata[39]);
                    fail_count++;
                end
            end
        end
    end

    // Block until every queued item was taken and answered, then let it settle.
    task automatic drain();
        wait (cmd_queue.size() == 0 && answer_queue.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_chain(bit v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        chain_on = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_random(int n);
        repeat (n) add_cmd(random_cmd());
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_data = 1'b1;
        cycle_count = 0;
        fail_count = 0;
        list_len = 0;
        play_pos = 0;
        play_prog = 0;
        chain_on = 1'b1;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty-list playback, field extremes, clamps, bad indexes,
        // growth by write, full list, remove fix-up, unknown codes.
        set_chain(1'b1);
        add_cmd(make_cmd(CMD_ADVANCE, 0, 0, 0, 0));
        add_cmd(make_cmd(CMD_READ, 0, 0, 0, 0));
        add_cmd(make_cmd(CMD_APPEND, 0, 255, 255, 1));
        add_cmd(make_cmd(CMD_APPEND, 0, 0, 0, 0));
        add_cmd(make_cmd(CMD_APPEND, 63, 170, 85, 1));
        add_cmd(make_cmd(CMD_SET_REP, 0, 0, 0, 0));
        add_cmd(make_cmd(CMD_SET_REP, 2, 0, 255, 0));
        add_cmd(make_cmd(CMD_SET_REP, 1, 0, 100, 0));
        add_cmd(make_cmd(CMD_SET_SKIP, 1, 0, 0, 1));
        add_cmd(make_cmd(CMD_READ, 2, 0, 0, 0));
        add_cmd(make_cmd(CMD_READ, 63, 0, 0, 0));
        add_cmd(make_cmd(CMD_PEEK, 0, 0, 0, 0));
        add_cmd(make_cmd(CMD_ADVANCE, 0, 0, 0, 0));
        add_cmd(make_cmd(CMD_ADVANCE, 0, 0, 0, 0));
        add_cmd(make_cmd(CMD_SEEK, 2, 0, 0, 0));
        add_cmd(make_cmd(CMD_REMOVE, 2, 0, 0, 0));
        add_cmd(make_cmd(CMD_REMOVE, 9, 0, 0, 0));
        add_cmd(make_cmd(CMD_WRITE, 63, 85, 0, 0));
        add_cmd(make_cmd(CMD_READ, 40, 0, 0, 0));
        add_cmd(make_cmd(CMD_APPEND, 0, 1, 0, 0));
        add_cmd(make_cmd(CMD_SEEK, 63, 0, 0, 0));
        add_cmd(make_cmd(CMD_REWIND, 0, 0, 0, 0));
        add_cmd(make_cmd(CMD_UNKNOWN_LO, 63, 255, 255, 1));
        add_cmd(make_cmd(CMD_UNKNOWN_HI, 0, 0, 0, 0));
        add_cmd(make_cmd(CMD_CLEAR, 0, 0, 0, 0));
        drain();

        // Playback disabled: advance and peek must leave the list alone
        set_chain(1'b0);
        repeat (6) add_cmd(make_cmd(CMD_APPEND, 0, $urandom_range(0, 255), 0, 0));
        queue_random(60);
        drain();

        set_chain(1'b1);
        queue_random(380);
        // fill past the top so the full status shows up, then play a long list
        add_cmd(make_cmd(CMD_CLEAR, 0, 0, 0, 0));
        repeat (66) add_cmd(make_cmd(CMD_APPEND, 0, $urandom_range(0, 255), 0, 0));
        repeat (12)
            add_cmd(make_cmd(CMD_SET_SKIP, $urandom_range(0, 63), 0, 0, 1));
        repeat (20) add_cmd(make_cmd(CMD_ADVANCE, 0, 0, 0, 0));
        add_cmd(make_cmd(CMD_REMOVE, 63, 0, 0, 0));
        add_cmd(make_cmd(CMD_REMOVE, 0, 0, 0, 0));
        drain();

        set_chain(1'b0);
        queue_random(30);
        drain();

        set_chain(1'b1);
        queue_random(250);
        drain();

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ===== repeat_playlist_sequencer_top.f =====
sv/rps_pkg.sv
sv/rps_mem.sv
sv/rps_ctrl.sv
sv/repeat_playlist_sequencer_top.sv
verif/repeat_playlist_sequencer_top_tb.sv
